/* rtl/hscb_pkg.sv */
// ----------------------------------------------------------------------------
// hscb_pkg
// Shared widths, operation and status codes, divider constants and types for
// the chained-bucket hash set.
// ----------------------------------------------------------------------------
package hscb_pkg;

    // table geometry
    localparam int NUM_BUCKETS      = 11;
    localparam int SLOTS_PER_BUCKET = 8;

    // field widths
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int BKT_OUT_W = 4;

    // internal index widths
    localparam int BKT_W  = $clog2(NUM_BUCKETS);
    localparam int BKT_XW = (BKT_W > BKT_OUT_W) ? BKT_W : BKT_OUT_W;
    localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int ROW_W  = SLOTS_PER_BUCKET * KEY_W;

    // reciprocal for key / NUM_BUCKETS: q = (key * RECIP) >> RECIP_SH, exact
    localparam int RECIP_W  = KEY_W + 2;
    localparam int RECIP_SH = KEY_W + $clog2(NUM_BUCKETS);
    localparam int PROD_W   = KEY_W + RECIP_W;
    localparam int QUOT_W   = PROD_W - RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << RECIP_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

    // request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // classified request passed from front to back
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [BKT_W-1:0]  bucket;
    } op_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } back_state_t;

endpackage

/* rtl/hscb_front.sv */
// ----------------------------------------------------------------------------
// hscb_front
// Accepts requests and computes the bucket index (key modulo bucket count)
// with a two-stage reciprocal multiply, then hands them to the queue.
// ----------------------------------------------------------------------------
module hscb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // [1:0] kind, [32:2] key, rest zero
    output logic              out_valid,
    input  logic              out_ready,
    output hscb_pkg::op_t     out_op
);

    // stage a: captured request
    logic                         a_valid_reg;
    logic [hscb_pkg::KIND_W-1:0]  a_kind_reg;
    logic [hscb_pkg::KEY_W-1:0]   a_key_reg;

    // stage b: request plus quotient
    logic                         b_valid_reg;
    logic [hscb_pkg::KIND_W-1:0]  b_kind_reg;
    logic [hscb_pkg::KEY_W-1:0]   b_key_reg;
    logic [hscb_pkg::QUOT_W-1:0]  b_quot_reg;

    logic                         b_free;
    logic                         a_move;
    logic                         accept;
    logic [hscb_pkg::PROD_W-1:0]  prod;
    logic [hscb_pkg::KEY_W-1:0]   quot_times_n;
    logic [hscb_pkg::KEY_W-1:0]   remainder;

    // pipeline flow control
    assign b_free        = !b_valid_reg || out_ready;
    assign a_move        = a_valid_reg && b_free;
    assign s_axis_tready = !a_valid_reg || b_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // reciprocal multiply for the quotient
    assign prod = hscb_pkg::PROD_W'(a_key_reg) * hscb_pkg::PROD_W'(hscb_pkg::RECIP);

    // remainder from the registered quotient
    assign quot_times_n = hscb_pkg::KEY_W'(hscb_pkg::KEY_W'(b_quot_reg)
                                           * hscb_pkg::KEY_W'(hscb_pkg::NUM_BUCKETS));
    assign remainder    = b_key_reg - quot_times_n;

    assign out_valid     = b_valid_reg;
    assign out_op.kind   = b_kind_reg;
    assign out_op.key    = b_key_reg;
    assign out_op.bucket = remainder[hscb_pkg::BKT_W-1:0];

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= accept || (a_valid_reg && !a_move);
            b_valid_reg <= a_move || (b_valid_reg && !out_ready);
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_kind_reg <= s_axis_tdata[1:0];
            a_key_reg  <= s_axis_tdata[32:2];
        end
        if (a_move) begin
            b_kind_reg <= a_kind_reg;
            b_key_reg  <= a_key_reg;
            b_quot_reg <= prod[hscb_pkg::PROD_W-1:hscb_pkg::RECIP_SH];
        end
    end

    // the bucket index must always land inside the table
    a_bucket_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (32'(out_op.bucket) < 32'(hscb_pkg::NUM_BUCKETS)))
        else $error("bucket index out of range");

endmodule

/* rtl/hscb_fifo.sv */
// ----------------------------------------------------------------------------
// hscb_fifo
// Short request queue that decouples the front classifier from the back end.
// ----------------------------------------------------------------------------
module hscb_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  hscb_pkg::op_t     in_op,
    output logic              out_valid,
    input  logic              out_ready,
    output hscb_pkg::op_t     out_op
);

    hscb_pkg::op_t              entry_reg [hscb_pkg::Q_DEPTH];
    logic [hscb_pkg::Q_AW-1:0]  wr_ptr_reg;
    logic [hscb_pkg::Q_AW-1:0]  rd_ptr_reg;
    logic [hscb_pkg::Q_AW:0]    count_reg;
    logic                       push;
    logic                       pop;

    // occupancy flags
    assign in_ready  = (count_reg != (hscb_pkg::Q_AW+1)'(hscb_pkg::Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_op    = entry_reg[rd_ptr_reg];

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (hscb_pkg::Q_AW+1)'(hscb_pkg::Q_DEPTH))
        else $error("queue count exceeds depth");

endmodule

/* rtl/hscb_back.sv */
// ----------------------------------------------------------------------------
// hscb_back
// Executes queued requests: reads the bucket row, compares all slots at once,
// writes back the changed key row or valid bits and registers the result.
// ----------------------------------------------------------------------------
module hscb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  hscb_pkg::op_t     q_op,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata    // [1:0] status, [5:2] bucket, rest zero
);

    hscb_pkg::back_state_t state_reg;
    hscb_pkg::back_state_t state_next;

    // key rows, one per bucket, and their valid bits
    logic [hscb_pkg::ROW_W-1:0]            key_mem [hscb_pkg::NUM_BUCKETS];
    logic [hscb_pkg::ROW_W-1:0]            row_rdata_reg;
    logic [hscb_pkg::SLOTS_PER_BUCKET-1:0] valid_reg [hscb_pkg::NUM_BUCKETS];

    hscb_pkg::op_t                         item_reg;

    logic                                  m_valid_reg;
    logic [hscb_pkg::STATUS_W-1:0]         m_status_reg;
    logic [hscb_pkg::BKT_OUT_W-1:0]        m_bucket_reg;

    logic                                  rd_en;
    logic                                  out_free;
    logic                                  out_load;
    logic                                  wr_en;
    logic                                  valid_wr;

    logic [hscb_pkg::SLOTS_PER_BUCKET-1:0] row_valid;
    logic [hscb_pkg::SLOTS_PER_BUCKET-1:0] hit;
    logic                                  match_any;
    logic [hscb_pkg::SLOT_W-1:0]           match_idx;
    logic                                  free_any;
    logic [hscb_pkg::SLOT_W-1:0]           free_idx;

    logic [hscb_pkg::STATUS_W-1:0]         status_c;
    logic [hscb_pkg::ROW_W-1:0]            row_wdata;
    logic [hscb_pkg::SLOTS_PER_BUCKET-1:0] row_valid_next;
    logic [hscb_pkg::BKT_XW-1:0]           bucket_x;

    assign out_free = !m_valid_reg || m_axis_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hscb_pkg::BK_IDLE: begin
                if (q_valid) begin
                    state_next = hscb_pkg::BK_READ;
                end
            end
            hscb_pkg::BK_READ: begin
                state_next = hscb_pkg::BK_EXEC;
            end
            hscb_pkg::BK_EXEC: begin
                if (out_free) begin
                    state_next = hscb_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = hscb_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        q_ready  = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            hscb_pkg::BK_IDLE: begin
                q_ready = 1'b1;
                rd_en   = q_valid;
            end
            hscb_pkg::BK_READ: begin
            end
            hscb_pkg::BK_EXEC: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hscb_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // slot compare against the fetched row
    assign row_valid = valid_reg[item_reg.bucket];

    always_comb begin
        for (int s = 0; s < hscb_pkg::SLOTS_PER_BUCKET; s++) begin
            hit[s] = row_valid[s]
                     && (row_rdata_reg[s*hscb_pkg::KEY_W +: hscb_pkg::KEY_W] == item_reg.key);
        end
    end

    // lowest matching slot and lowest free slot
    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        free_any  = 1'b0;
        free_idx  = '0;
        for (int s = hscb_pkg::SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
            if (hit[s]) begin
                match_any = 1'b1;
                match_idx = hscb_pkg::SLOT_W'(s);
            end
            if (!row_valid[s]) begin
                free_any = 1'b1;
                free_idx = hscb_pkg::SLOT_W'(s);
            end
        end
    end

    // operation decode
    always_comb begin
        status_c       = hscb_pkg::ST_MISSING;
        row_wdata      = row_rdata_reg;
        row_valid_next = row_valid;
        wr_en          = 1'b0;
        valid_wr       = 1'b0;
        case (item_reg.kind)
            hscb_pkg::KIND_INSERT: begin
                if (free_any) begin
                    status_c = hscb_pkg::ST_OK;
                    row_wdata[free_idx*hscb_pkg::KEY_W +: hscb_pkg::KEY_W] = item_reg.key;
                    row_valid_next[free_idx] = 1'b1;
                    wr_en    = out_load;
                    valid_wr = out_load;
                end else begin
                    status_c = hscb_pkg::ST_FULL;
                end
            end
            hscb_pkg::KIND_REMOVE: begin
                if (match_any) begin
                    status_c = hscb_pkg::ST_OK;
                    row_valid_next[match_idx] = 1'b0;
                    valid_wr = out_load;
                end
            end
            default: begin
                // search, and the unused code
                status_c = match_any ? hscb_pkg::ST_OK : hscb_pkg::ST_MISSING;
            end
        endcase
    end

    // key row memory
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            row_rdata_reg <= key_mem[q_op.bucket];
        end
        if (wr_en) begin
            key_mem[item_reg.bucket] <= row_wdata;
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < hscb_pkg::NUM_BUCKETS; b++) begin
                valid_reg[b] <= '0;
            end
        end else if (valid_wr) begin
            valid_reg[item_reg.bucket] <= row_valid_next;
        end
    end

    // request capture on pop
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            item_reg <= q_op;
        end
    end

    // result register
    assign bucket_x = hscb_pkg::BKT_XW'(item_reg.bucket);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= out_load || (m_valid_reg && !m_axis_tready);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= status_c;
            m_bucket_reg <= bucket_x[hscb_pkg::BKT_OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_bucket_reg, m_status_reg};

    // a stalled result keeps the sequencer parked on the current request
    a_exec_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hscb_pkg::BK_EXEC && !out_free) |=> state_reg == hscb_pkg::BK_EXEC)
        else $error("sequencer left exec while result was stalled");

    // key rows are only rewritten by a successful insert
    a_write_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (out_load && item_reg.kind == hscb_pkg::KIND_INSERT && free_any))
        else $error("key row written outside a successful insert");

endmodule

/* rtl/hash_set_chained_buckets.sv */
// The back end takes one request at a time: it reads the bucket row, compares,
//   writes any change back, goes idle only when the result register is free.
// The front accepts during back-end work until its stages and 4-entry queue fill.
// Reset: synchronous active-low; clears all slot valid bits at once, no sweep.
// ----------------------------------------------------------------------------
// hash_set_chained_buckets
// Hash set of 31-bit keys in fixed-size buckets, with insert, search and
// remove requests and one status result per request.
// ----------------------------------------------------------------------------
module hash_set_chained_buckets (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] kind, [32:2] key, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] status, [5:2] bucket, rest zero
);

    logic          fr_valid;
    logic          fr_ready;
    hscb_pkg::op_t fr_op;
    logic          q_valid;
    logic          q_ready;
    hscb_pkg::op_t q_op;

    // request classification
    hscb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_op        (fr_op)
    );

    // decoupling queue
    hscb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_op     (fr_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    // table execution
    hscb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_op          (q_op),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* tb/hash_set_chained_buckets_tb.sv */
// ----------------------------------------------------------------------------
// hash_set_chained_buckets_tb
// Drives insert, search and remove requests into the chained-bucket hash set
// and checks every status result against a local model of the bucket table.
// Directed requests cover the empty table, the extreme keys, a full bucket
// with duplicates and first-entry removal; random requests then work a small
// key pool so buckets fill up and drain, with random gaps on either side in some runs.
// ----------------------------------------------------------------------------
module hash_set_chained_buckets_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hscb_pkg::*;

    localparam int                TOTAL_SLOTS = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
    localparam int                POOL_SIZE   = 12;
    localparam int                RANDOM_RUNS = 4;
    localparam int                RUN_LENGTH  = 350;
    localparam int                MAX_Q       = 195225785;

    // one expected result
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [BKT_OUT_W-1:0] bucket;
    } set_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [1:0] kind, [32:2] key, rest zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [1:0] status, [5:2] bucket, rest zero

    // model of the bucket table
    logic [KEY_W-1:0] table_keys [TOTAL_SLOTS];
    logic             table_valid[TOTAL_SLOTS];

    set_result_t      pending_results[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    int               fail_count = 0;
    bit               send_gaps  = 1'b1;
    bit               recv_stalls = 1'b1;

    hash_set_chained_buckets uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2ms;
        $display("hash_set_chained_buckets regression: fail");
        $finish;
    end

    // apply one request to the table model and return its result
    function automatic set_result_t hash_set_apply(logic [KIND_W-1:0] kind,
                                                   logic [KEY_W-1:0] key);
        set_result_t res;
        int          bkt;
        int          row;
        int          hit;
        int          free_slot;
        bkt       = int'(key % NUM_BUCKETS);
        row       = bkt * SLOTS_PER_BUCKET;
        hit       = -1;
        free_slot = -1;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
            if (table_valid[row + s] && table_keys[row + s] == key)
                hit = s;
            if (!table_valid[row + s])
                free_slot = s;
        end
        res.bucket = BKT_OUT_W'(bkt);
        if (kind == KIND_INSERT) begin
            if (free_slot < 0) begin
                res.status = ST_FULL;
            end else begin
                table_keys[row + free_slot]  = key;
                table_valid[row + free_slot] = 1'b1;
                res.status = ST_OK;
            end
        end else if (kind == KIND_REMOVE) begin
            if (hit < 0) begin
                res.status = ST_MISSING;
            end else begin
                table_valid[row + hit] = 1'b0;
                res.status = ST_OK;
            end
        end else begin
            // search, and the spare kind code behaves the same
            res.status = (hit < 0) ? ST_MISSING : ST_OK;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // send one request, predict its result when the handshake is seen
    task automatic send_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
        int gap;
        gap = send_gaps ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, key, kind};
        do @(negedge aclk); while (!s_axis_tready);
        pending_results.push_back(hash_set_apply(kind, key));
        @(posedge aclk);
    endtask

    // hold off the sender until every result is back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // empty table: nothing to find or remove, spare kind acts as search
    task automatic test_empty_table();
        send_request(KIND_SEARCH, '0);
        send_request(KIND_REMOVE, '0);
        send_request(KIND_SPARE, '0);
    endtask

    // largest key, then remove it as the only entry and again when absent
    task automatic test_extreme_key();
        send_request(KIND_INSERT, '1);
        send_request(KIND_SEARCH, '1);
        send_request(KIND_SPARE, '1);
        send_request(KIND_REMOVE, '1);
        send_request(KIND_REMOVE, '1);
    endtask

    // fill bucket 0 with a duplicate, overflow it, remove the first entry
    task automatic test_full_bucket();
        for (int i = 0; i < SLOTS_PER_BUCKET - 1; i++)
            send_request(KIND_INSERT, KEY_W'(i * NUM_BUCKETS));
        send_request(KIND_INSERT, '0);
        send_request(KIND_INSERT, KEY_W'((SLOTS_PER_BUCKET - 1) * NUM_BUCKETS));
        send_request(KIND_REMOVE, '0);
        send_request(KIND_SEARCH, '0);
        send_request(KIND_REMOVE, '0);
        send_request(KIND_SEARCH, '0);
    endtask

    // random requests over a small key pool so buckets collide and fill
    task automatic test_random_mix();
        int               pick;
        int               target;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        for (int run = 0; run < RANDOM_RUNS; run++) begin
            send_gaps   = (run == 0) || (run == 2);
            recv_stalls = (run == 0) || (run == 3);
            target = $urandom_range(0, NUM_BUCKETS - 1);
            for (int i = 0; i < POOL_SIZE; i++) begin
                if (i % 2 == 0)
                    key_pool[i] = KEY_W'($urandom_range(0, MAX_Q) * NUM_BUCKETS + target);
                else
                    key_pool[i] = KEY_W'($urandom());
            end
            for (int n = 0; n < RUN_LENGTH; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    kind = KIND_INSERT;
                else if (pick < 65)
                    kind = KIND_SEARCH;
                else if (pick < 95)
                    kind = KIND_REMOVE;
                else
                    kind = KIND_SPARE;
                if ($urandom_range(0, 3) != 0)
                    key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    key = KEY_W'($urandom());
                send_request(kind, key);
            end
            if (run == 1)
                wait_for_drain();
        end
    endtask

    // result side: random stall before each result while stalls are enabled
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = recv_stalls ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge aclk); while (!m_axis_tvalid);
            @(posedge aclk);
        end
    end

    // compare each result with the oldest expectation
    always @(negedge aclk) begin
        set_result_t exp_res;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== exp_res.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tdata[1:0], exp_res.status));
                if (m_axis_tdata[5:2] !== exp_res.bucket)
                    report_mismatch($sformatf("bucket %0d, expected %0d",
                                              m_axis_tdata[5:2], exp_res.bucket));
            end
        end
    end

    // reset, test sequence and end of run
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        for (int i = 0; i < TOTAL_SLOTS; i++) begin
            table_keys[i]  = '0;
            table_valid[i] = 1'b0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_extreme_key();
        test_full_bucket();
        wait_for_drain();
        test_random_mix();

        wait_for_drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("hash_set_chained_buckets regression: pass");
        else
            $display("hash_set_chained_buckets regression: fail");
        $finish;
    end

endmodule
